### rtl/seld_pkg.sv
package seld_pkg;

  localparam int unsigned LENGTH_POSITION = 1;

  localparam logic [7:0] LEN_POS = 8'(LENGTH_POSITION);
  localparam logic [7:0] MIN_LEN = 8'(LENGTH_POSITION + 2);

  localparam logic [7:0] START_BYTE_RST = 8'h02;
  localparam logic [7:0] END_BYTE_RST   = 8'h03;
  localparam logic [7:0] SUM_INIT       = 8'h00;

  typedef enum logic [1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_END_BYTE   = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_CSUM_BAD  = 2'd1,
    ST_LEN_SMALL = 2'd2,
    ST_NO_END    = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [7:0]    frame_byte;
    logic [7:0]    byte_position;
    logic          frame_end;
    frame_status_t frame_status;
  } res_t;

endpackage

### rtl/seld_in_stage.sv
module seld_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       advance,
  output logic       take,
  output logic [7:0] rx_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign take      = valid_r && advance;
  assign in_tready = !valid_r || advance;
  assign rx_byte   = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

endmodule

### rtl/seld_core.sv
module seld_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 take,
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  output seld_pkg::res_t       res
);
  import seld_pkg::*;

  logic [7:0] start_byte_r, start_byte_nxt;
  logic [7:0] end_byte_r, end_byte_nxt;
  logic       in_frame_r, in_frame_nxt;
  logic [7:0] position_count_r, position_count_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic       checksum_matched_r, checksum_matched_nxt;
  logic [7:0] pos;
  logic [7:0] len;

  always_comb begin
    start_byte_nxt = start_byte_r;
    end_byte_nxt   = end_byte_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_START_BYTE: start_byte_nxt = cfg_data;
        CFG_END_BYTE:   end_byte_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame_nxt         = in_frame_r;
    position_count_nxt   = position_count_r;
    frame_length_nxt     = frame_length_r;
    running_sum_nxt      = running_sum_r;
    checksum_matched_nxt = checksum_matched_r;
    pos                  = position_count_r + 8'd1;
    len                  = frame_length_r;
    res.frame_byte       = rx_byte;
    res.byte_position    = 8'd0;
    res.frame_end        = 1'b0;
    res.frame_status     = ST_GOOD;
    res_valid            = 1'b0;

    if (!in_frame_r) begin
      if (rx_byte == start_byte_r) begin
        res_valid            = 1'b1;
        in_frame_nxt         = 1'b1;
        position_count_nxt   = 8'd0;
        frame_length_nxt     = 8'd0;
        running_sum_nxt      = SUM_INIT;
        checksum_matched_nxt = 1'b0;
      end
    end else begin
      res_valid         = 1'b1;
      res.byte_position = pos;
      if (pos == LEN_POS) begin
        len              = rx_byte;
        frame_length_nxt = rx_byte;
      end
      if (pos < LEN_POS) begin
        running_sum_nxt = running_sum_r + rx_byte;
      end else if (len < MIN_LEN) begin
        res.frame_end    = 1'b1;
        res.frame_status = ST_LEN_SMALL;
      end else if (pos == len - 8'd1) begin
        res.frame_end = 1'b1;
        if (rx_byte != end_byte_r) begin
          res.frame_status = ST_NO_END;
        end else if (checksum_matched_r) begin
          res.frame_status = ST_GOOD;
        end else begin
          res.frame_status = ST_CSUM_BAD;
        end
      end else if (pos == len - 8'd2) begin
        checksum_matched_nxt = (running_sum_r == rx_byte);
      end else begin
        running_sum_nxt = running_sum_r + rx_byte;
      end

      if (res.frame_end) begin
        in_frame_nxt         = 1'b0;
        position_count_nxt   = 8'd0;
        frame_length_nxt     = 8'd0;
        running_sum_nxt      = SUM_INIT;
        checksum_matched_nxt = 1'b0;
      end else begin
        position_count_nxt = pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r       <= START_BYTE_RST;
      end_byte_r         <= END_BYTE_RST;
      in_frame_r         <= 1'b0;
      position_count_r   <= 8'd0;
      frame_length_r     <= 8'd0;
      running_sum_r      <= SUM_INIT;
      checksum_matched_r <= 1'b0;
    end else begin
      start_byte_r <= start_byte_nxt;
      end_byte_r   <= end_byte_nxt;
      if (take) begin
        in_frame_r         <= in_frame_nxt;
        position_count_r   <= position_count_nxt;
        frame_length_r     <= frame_length_nxt;
        running_sum_r      <= running_sum_nxt;
        checksum_matched_r <= checksum_matched_nxt;
      end
    end
  end

`ifndef SYNTH
  a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (position_count_r == 8'd0 && running_sum_r == SUM_INIT
                     && frame_length_r == 8'd0 && !checksum_matched_r))
    else $error("hunting with stale frame state");
  a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_valid && res.frame_end) |=> !in_frame_r)
    else $error("frame end did not return to hunting");
  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !in_frame_r && res_valid) |=> in_frame_r)
    else $error("start byte did not open a frame");
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.frame_end) |-> res.frame_status == ST_GOOD)
    else $error("status set on a non-final byte");
`endif

endmodule

### rtl/seld_out_stage.sv
module seld_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  logic           res_valid,
  input  seld_pkg::res_t res,
  output logic           advance,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata,  // [7:0] frame_byte, [15:8] byte_position
  output logic           out_tlast,  // frame_end
  output logic [1:0]     out_tuser   // [1:0] frame_status
);
  import seld_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign advance    = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.byte_position, res_r.frame_byte};
  assign out_tlast  = res_r.frame_end;
  assign out_tuser  = res_r.frame_status;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res;
    end
  end

endmodule

### rtl/stx_etx_length_checksum_deframer.sv
// STX/ETX deframer: one received byte per item. Bytes seen while hunting that
// are not the start byte give no result. Every frame byte comes out with its
// position (start byte is 0); the final byte has tlast set and its status in
// tuser (0 good, 1 checksum mismatch, 2 length too small, 3 missing end byte).
// The length is read at frame position LENGTH_POSITION of the package.
// Timing: an accepted byte is held in the input register, the frame state and
// result are worked out from it combinationally, and the result is loaded
// into the output register, which drives out_tvalid, when the byte leaves
// the input register. With out_tready high one item is taken every clock.
// While a result waits with out_tready low nothing leaves the input register,
// bytes that give no result included, so the input takes at most one more
// byte and then holds in_tready low.
// Register 0 is the start byte (reset 0x02), register 1 the end byte (reset
// 0x03); other indices are ignored. cfg_ready is always high.
module stx_etx_length_checksum_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] frame_byte, [15:8] byte_position
  output logic        out_tlast,   // frame_end
  output logic [1:0]  out_tuser,   // [1:0] frame_status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import seld_pkg::*;

  logic       advance;
  logic       take;
  logic [7:0] rx_byte;
  logic       res_valid;
  res_t       res;

  assign cfg_ready = 1'b1;

  seld_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .take      (take),
    .rx_byte   (rx_byte)
  );

  seld_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  seld_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");
  a_no_status_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> out_tuser == ST_GOOD)
    else $error("status on a non-final item");
`endif

endmodule
